// ===== hw/rtl/u8rs_pkg.sv =====
`default_nettype none

package u8rs_pkg;

   // byte values used by the decoder
   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] CONT_MAX   = 8'hBF;
   localparam logic [7:0] LEAD2_MIN  = 8'hC2;
   localparam logic [7:0] LEAD2_MAX  = 8'hDF;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD3_MAX  = 8'hEF;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD4_MAX  = 8'hF4;
   localparam logic [7:0] LEAD_SURR  = 8'hED;
   localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
   localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
   localparam logic [7:0] F0_SECOND_MIN = 8'h90;
   localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

   // U+FFFD in utf-8
   localparam logic [7:0] REPL_BYTE0 = 8'hEF;
   localparam logic [7:0] REPL_BYTE1 = 8'hBF;
   localparam logic [7:0] REPL_BYTE2 = 8'hBD;

   localparam logic [2:0] LEN_BAD   = 3'd0;
   localparam logic [2:0] LEN_ASCII = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // one output character: up to four bytes, first byte in bytes[0]
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
      logic            repl;
      logic [31:0]     count;
   } char_type;

   // work for the back part caused by one input byte
   typedef struct packed {
      char_type [1:0] chars;
      logic           two;
      logic           eos;
   } item_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      len = LEN_BAD;
      if (b <= ASCII_MAX) begin
         len = LEN_ASCII;
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
         len = LEN_TWO;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
         len = LEN_THREE;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

   // overlong, surrogate and above-range limits on the second byte
   function automatic logic seq_ok(input logic [7:0] lead, input logic [7:0] second);
      logic ok;
      case (lead)
         LEAD3_MIN: ok = (second >= E0_SECOND_MIN);
         LEAD_SURR: ok = (second <= ED_SECOND_MAX);
         LEAD4_MIN: ok = (second >= F0_SECOND_MIN);
         LEAD4_MAX: ok = (second <= F4_SECOND_MAX);
         default:   ok = 1'b1;
      endcase
      return ok;
   endfunction

   function automatic char_type repl_char();
      char_type c;
      c = '0;
      c.bytes[0] = REPL_BYTE0;
      c.bytes[1] = REPL_BYTE1;
      c.bytes[2] = REPL_BYTE2;
      c.len      = LEN_THREE;
      c.repl     = 1'b1;
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8rs_front.sv =====
`default_nettype none

module u8rs_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_eos,
   output logic                    push_valid,
   output u8rs_pkg::item_type      push_item,
   input  wire logic               queue_full
);

   localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [7:0]             lead_ff, lead_in;
   logic [2:0]             exp_ff, exp_in;
   logic [1:0]             coll_ff, coll_in;
   logic [2:0][7:0]        buf_ff, buf_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic [COUNT_WIDTH-1:0] inc1, inc2;
   logic [EXT_W-1:0]       ext1, ext2;
   logic [31:0]            count1, count2;
   logic                   accept;

   u8rs_pkg::char_type [1:0] chars;
   logic [1:0]               nch;
   logic                     do_lead;
   logic [2:0]               ll;
   u8rs_pkg::char_type       seq_char;

   // counts for the first and second character started by this byte
   assign inc1   = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + COUNT_WIDTH'(1);
   assign inc2   = (cnt_ff >= CNT_MAX - COUNT_WIDTH'(1)) ? CNT_MAX : cnt_ff + COUNT_WIDTH'(2);
   assign ext1   = EXT_W'(inc1);
   assign ext2   = EXT_W'(inc2);
   assign count1 = (ext1 > EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext1[31:0];
   assign count2 = (ext2 > EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext2[31:0];

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign ll       = u8rs_pkg::lead_len(in_byte);

   always_comb begin
      lead_in  = lead_ff;
      exp_in   = exp_ff;
      coll_in  = coll_ff;
      buf_in   = buf_ff;
      chars    = '0;
      nch      = 2'd0;
      do_lead  = 1'b0;
      seq_char = '0;

      if (exp_ff != 3'd0) begin
         if (in_byte[7:6] == 2'b10) begin
            if (coll_ff != 2'd3) begin
               buf_in[coll_ff] = in_byte;
            end
            coll_in = coll_ff + 2'd1;
            if ({1'b0, coll_ff} + 3'd2 >= exp_ff) begin
               if (u8rs_pkg::seq_ok(lead_ff, buf_in[0])) begin
                  seq_char.bytes[0] = lead_ff;
                  seq_char.bytes[1] = buf_in[0];
                  seq_char.bytes[2] = buf_in[1];
                  seq_char.bytes[3] = buf_in[2];
                  seq_char.len      = exp_ff;
                  chars[nch[0]]     = seq_char;
               end else begin
                  chars[nch[0]] = u8rs_pkg::repl_char();
               end
               nch     = nch + 2'd1;
               lead_in = 8'd0;
               exp_in  = 3'd0;
               coll_in = 2'd0;
            end
         end else begin
            // broken sequence, the breaking byte starts over as a lead
            chars[nch[0]] = u8rs_pkg::repl_char();
            nch     = nch + 2'd1;
            lead_in = 8'd0;
            exp_in  = 3'd0;
            coll_in = 2'd0;
            do_lead = 1'b1;
         end
      end else begin
         do_lead = 1'b1;
      end

      if (do_lead) begin
         if (ll == u8rs_pkg::LEN_ASCII) begin
            seq_char.bytes[0] = in_byte;
            seq_char.len      = u8rs_pkg::LEN_ASCII;
            chars[nch[0]]     = seq_char;
            nch               = nch + 2'd1;
         end else if (ll == u8rs_pkg::LEN_BAD) begin
            chars[nch[0]] = u8rs_pkg::repl_char();
            nch           = nch + 2'd1;
         end else begin
            lead_in = in_byte;
            exp_in  = ll;
            coll_in = 2'd0;
         end
      end

      // sequence cut off by the end of the string
      if (in_eos && exp_in != 3'd0) begin
         chars[nch[0]] = u8rs_pkg::repl_char();
         nch     = nch + 2'd1;
         lead_in = 8'd0;
         exp_in  = 3'd0;
         coll_in = 2'd0;
      end

      chars[0].count = count1;
      chars[1].count = count2;

      case (nch)
         2'd1:    cnt_in = inc1;
         2'd2:    cnt_in = inc2;
         default: cnt_in = cnt_ff;
      endcase
      if (in_eos) begin
         cnt_in = '0;
      end
   end

   assign push_valid      = accept && (nch != 2'd0);
   assign push_item.chars = chars;
   assign push_item.two   = nch[1];
   assign push_item.eos   = in_eos;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= 8'd0;
         exp_ff  <= 3'd0;
         coll_ff <= 2'd0;
         cnt_ff  <= '0;
      end else if (accept) begin
         lead_ff <= lead_in;
         exp_ff  <= exp_in;
         coll_ff <= coll_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= buf_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/u8rs_queue.sv =====
`default_nettype none

module u8rs_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u8rs_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output u8rs_pkg::item_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   u8rs_pkg::item_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/u8rs_back.sv =====
`default_nettype none

module u8rs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire u8rs_pkg::item_type head,
   output logic                    pop,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [7:0]              out_byte,
   output logic                    out_run_last,
   output logic                    out_text_end,
   output logic [31:0]             out_count,
   output logic                    out_repl
);

   logic        char_idx_ff;
   logic [1:0]  byte_idx_ff;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic        run_last_ff, text_end_ff, repl_ff;
   logic [31:0] count_ff;

   u8rs_pkg::char_type cur;
   logic               last_byte, last_char, load;

   assign cur       = head.chars[char_idx_ff];
   assign last_byte = ({1'b0, byte_idx_ff} + 3'd1 == cur.len);
   assign last_char = char_idx_ff || !head.two;
   assign load      = head_valid && (!valid_ff || out_ready);
   assign pop       = load && last_byte && last_char;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         char_idx_ff <= 1'b0;
         byte_idx_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            if (last_byte) begin
               byte_idx_ff <= 2'd0;
               char_idx_ff <= !last_char;
            end else begin
               byte_idx_ff <= byte_idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= cur.bytes[byte_idx_ff];
         run_last_ff <= last_byte && last_char;
         text_end_ff <= last_byte && last_char && head.eos;
         count_ff    <= cur.count;
         repl_ff     <= cur.repl;
      end
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign out_run_last = run_last_ff;
   assign out_text_end = text_end_ff;
   assign out_count    = count_ff;
   assign out_repl     = repl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_repair_stream.sv =====
// a result byte passes through a queue entry and then the output register; one input
// byte per clock while rsp_tready is high and each byte yields at most one result
// byte; the output register moves one byte per clock while rsp_tready is high, so a
// longer expansion holds the back end and the queue of QUEUE_DEPTH items absorbs it
// reset: synchronous, active high; clears any pending sequence, the character
// counter, the queue and the output register
`default_nettype none

module utf8_repair_stream #(
   parameter int COUNT_WIDTH = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // input byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] in_byte
   input  wire logic        req_tlast,    // end_of_string

   // repaired byte stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,    // [7:0] out_byte, [39:8] char_count
   output logic             rsp_tlast,    // text_end
   output logic [1:0]       rsp_tuser     // [0] run_last, [1] is_replacement
);

   // front to queue
   logic               push_valid;
   u8rs_pkg::item_type push_item;
   logic               queue_full;

   // queue to back
   logic               queue_empty;
   logic               pop;
   u8rs_pkg::item_type head;

   // back outputs
   logic [7:0]  out_byte;
   logic [31:0] out_count;
   logic        out_run_last;
   logic        out_repl;

   // front: decodes each byte against the pending sequence and turns it into
   // zero, one or two output characters with their counts
   u8rs_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_eos     (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   // short queue so a multi-byte expansion does not stall the input side at once
   u8rs_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   // back: walks the bytes of the queued characters into the output register
   u8rs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (!queue_empty),
      .head         (head),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (out_byte),
      .out_run_last (out_run_last),
      .out_text_end (rsp_tlast),
      .out_count    (out_count),
      .out_repl     (out_repl)
   );

   assign rsp_tdata = {out_count, out_byte};
   assign rsp_tuser = {out_repl, out_run_last};

endmodule

`default_nettype wire
